/* rtl/polynomial_term_accumulate_evaluate_core_assert.svh */
// assertion macros used by the checker file
`ifndef POLYNOMIAL_TERM_ACCUMULATE_EVALUATE_CORE_ASSERT_SVH
`define POLYNOMIAL_TERM_ACCUMULATE_EVALUATE_CORE_ASSERT_SVH

// same-cycle implication, off while in reset
`define PTAE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptae check failed");

// next-cycle implication, off while in reset
`define PTAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptae check failed");

`endif

/* rtl/ptae_pkg.sv */
package ptae_pkg;

    localparam int DATA_W         = 32;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int DEG_W          = 4;
    localparam int CMD_W          = 2;
    localparam int MAX_DEGREE_DEF = 15;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // q16.16 range seen through the wide adder
    localparam logic signed [PROD_W-1:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] Q_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_ACC,
        S_EV_RD,
        S_EV_LOAD,
        S_EV_MUL,
        S_EV_ACC,
        S_CLEAR,
        S_ZERO,
        S_DONE
    } t_state;

    typedef struct packed {
        logic zero;      // result forced to zero
        logic load;      // accumulator takes the store word
        logic mul;       // product register takes acc * x
        logic acc_add;   // acc = clamp(store word + coefficient)
        logic acc_eval;  // acc = clamp(round(product) + store word)
    } t_mac_ctrl;

    typedef struct packed {
        logic clear;
        logic we;
    } t_store_ctrl;

endpackage

/* rtl/ptae_cmd_if.sv */
interface ptae_cmd_if;
    import ptae_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] term_coefficient;
    logic [DEG_W-1:0]         term_degree;
    logic signed [DATA_W-1:0] eval_point;

    modport source (output valid, cmd, term_coefficient, term_degree, eval_point,
                    input ready);
    modport sink   (input valid, cmd, term_coefficient, term_degree, eval_point,
                    output ready);
endinterface

/* rtl/ptae_res_if.sv */
interface ptae_res_if;
    import ptae_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     saturated;

    modport source (output valid, value, saturated, input ready);
    modport sink   (input valid, value, saturated, output ready);
endinterface

/* rtl/ptae_coef_store.sv */
module ptae_coef_store #(
    parameter int DEPTH  = ptae_pkg::MAX_DEGREE_DEF + 1,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ptae_pkg::t_store_ctrl              i_ctrl,
    input  logic [ADDR_W-1:0]                  i_waddr,
    input  logic signed [ptae_pkg::DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]                  i_raddr,
    output logic signed [ptae_pkg::DATA_W-1:0] o_rdata
);
    import ptae_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]         r_valid;
    logic signed [DATA_W-1:0] r_rdata;
    logic                     r_rvalid;

    // entries never written since clear read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_valid <= '0;
        end else if (i_ctrl.we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata  <= r_mem[i_raddr];
        r_rvalid <= r_valid[i_raddr];
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;
endmodule

/* rtl/ptae_mac.sv */
module ptae_mac #(
    parameter int FRAC_BITS = ptae_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  ptae_pkg::t_mac_ctrl                i_ctrl,
    input  logic signed [ptae_pkg::DATA_W-1:0] i_x,
    input  logic signed [ptae_pkg::DATA_W-1:0] i_coef,
    input  logic signed [ptae_pkg::DATA_W-1:0] i_rdata,
    output logic signed [ptae_pkg::DATA_W-1:0] o_sum,
    output logic signed [ptae_pkg::DATA_W-1:0] o_acc,
    output logic                               o_sat
);
    import ptae_pkg::*;

    // round to nearest, ties up
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'((64'd1 << FRAC_BITS) >> 1);

    logic signed [DATA_W-1:0] r_acc;
    logic                     r_sat;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_biased;
    logic signed [PROD_W-1:0] w_rnd;
    logic signed [PROD_W-1:0] w_opa;
    logic signed [PROD_W-1:0] w_opb;
    logic signed [PROD_W-1:0] w_sum;
    logic                     w_hi;
    logic                     w_lo;
    logic                     w_clip;
    logic signed [DATA_W-1:0] w_clamped;

    assign w_prod   = r_acc * i_x;
    assign w_biased = r_prod + HALF;
    assign w_rnd    = w_biased >>> FRAC_BITS;

    // one adder serves both the coefficient add and the horner step
    assign w_opa = i_ctrl.acc_add ? PROD_W'(i_rdata) : w_rnd;
    assign w_opb = i_ctrl.acc_add ? PROD_W'(i_coef)  : PROD_W'(i_rdata);
    assign w_sum = w_opa + w_opb;

    assign w_hi   = w_sum > Q_MAX;
    assign w_lo   = w_sum < Q_MIN;
    assign w_clip = w_hi | w_lo;

    always_comb begin
        if (w_hi) begin
            w_clamped = Q_MAX[DATA_W-1:0];
        end else if (w_lo) begin
            w_clamped = Q_MIN[DATA_W-1:0];
        end else begin
            w_clamped = w_sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.zero) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (i_ctrl.load) begin
            r_acc <= i_rdata;
            r_sat <= 1'b0;
        end else if (i_ctrl.acc_add) begin
            r_acc <= w_clamped;
            r_sat <= w_clip;
        end else if (i_ctrl.acc_eval) begin
            r_acc <= w_clamped;
            r_sat <= r_sat | w_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod <= w_prod;
        end
    end

    assign o_sum = w_clamped;
    assign o_acc = r_acc;
    assign o_sat = r_sat;
endmodule

/* rtl/ptae_seq.sv */
module ptae_seq #(
    parameter int MAX_DEGREE = ptae_pkg::MAX_DEGREE_DEF,
    parameter int ADDR_W     = $clog2(MAX_DEGREE + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic [ptae_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [ptae_pkg::DATA_W-1:0] i_term_coefficient,
    input  logic [ptae_pkg::DEG_W-1:0]         i_term_degree,
    input  logic signed [ptae_pkg::DATA_W-1:0] i_eval_point,
    output logic                               o_in_ready,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output ptae_pkg::t_mac_ctrl                o_mac_ctrl,
    output ptae_pkg::t_store_ctrl              o_store_ctrl,
    output logic [ADDR_W-1:0]                  o_waddr,
    output logic [ADDR_W-1:0]                  o_raddr,
    output logic signed [ptae_pkg::DATA_W-1:0] o_coef,
    output logic signed [ptae_pkg::DATA_W-1:0] o_x
);
    import ptae_pkg::*;

    t_state                   r_state;
    t_state                   n_state;
    logic [ADDR_W-1:0]        r_deg;
    logic [ADDR_W-1:0]        n_deg;
    logic [DEG_W-1:0]         r_term_degree;
    logic signed [DATA_W-1:0] r_coef;
    logic signed [DATA_W-1:0] r_x;
    logic                     w_accept;
    logic                     w_deg_ok;
    logic [ADDR_W-1:0]        w_deg_addr;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_deg_ok   = int'(i_term_degree) <= MAX_DEGREE;
    assign w_deg_addr = ADDR_W'(r_term_degree);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_deg <= n_deg;
        if (w_accept) begin
            r_term_degree <= i_term_degree;
            r_coef        <= i_term_coefficient;
            r_x           <= i_eval_point;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_cmd)
                        CMD_ADD:   n_state = w_deg_ok ? S_ADD_RD : S_ZERO;
                        CMD_EVAL:  n_state = S_EV_RD;
                        CMD_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_ZERO;
                    endcase
                end
            end
            S_ADD_RD:  n_state = S_ADD_ACC;
            S_ADD_ACC: n_state = S_DONE;
            S_EV_RD:   n_state = S_EV_LOAD;
            S_EV_LOAD: n_state = S_EV_MUL;
            S_EV_MUL:  n_state = S_EV_ACC;
            S_EV_ACC:  n_state = (r_deg == '0) ? S_DONE : S_EV_MUL;
            S_CLEAR:   n_state = S_DONE;
            S_ZERO:    n_state = S_DONE;
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_mac_ctrl   = '0;
        o_store_ctrl = '0;
        o_raddr      = r_deg;
        n_deg        = r_deg;
        unique case (r_state)
            S_ADD_RD: o_raddr = w_deg_addr;
            S_ADD_ACC: begin
                o_mac_ctrl.acc_add = 1'b1;
                o_store_ctrl.we    = 1'b1;
            end
            S_EV_RD: o_raddr = ADDR_W'(MAX_DEGREE);
            S_EV_LOAD: begin
                o_mac_ctrl.load = 1'b1;
                n_deg           = ADDR_W'(MAX_DEGREE - 1);
            end
            S_EV_MUL: o_mac_ctrl.mul = 1'b1;
            S_EV_ACC: begin
                o_mac_ctrl.acc_eval = 1'b1;
                n_deg               = r_deg - ADDR_W'(1);
            end
            S_CLEAR: begin
                o_mac_ctrl.zero    = 1'b1;
                o_store_ctrl.clear = 1'b1;
            end
            S_ZERO: o_mac_ctrl.zero = 1'b1;
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_waddr     = w_deg_addr;
    assign o_coef      = r_coef;
    assign o_x         = r_x;
endmodule

/* rtl/polynomial_term_accumulate_evaluate_core.sv */
// channel     dir  handshake     word
// i_cmd_ch    in   valid/ready   cmd, term_coefficient, term_degree, eval_point
// o_res_ch    out  valid/ready   value, saturated
//
// one word in flight at a time; ready is high only while idle
// evaluate: the top coefficient is read and loaded, then each lower degree takes a multiply
//   step and a round/add/clamp step in the shared unit
// add: the stored coefficient is read, then added to and written back; clear and unused commands answer zero
// synchronous active-low reset; the store reads as all zero right after reset
// the result sits in the accumulator until the sink takes it
module polynomial_term_accumulate_evaluate_core #(
    parameter int MAX_DEGREE = ptae_pkg::MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = ptae_pkg::FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ptae_cmd_if.sink   i_cmd_ch,
    ptae_res_if.source o_res_ch
);
    import ptae_pkg::*;

    localparam int DEPTH  = MAX_DEGREE + 1;
    localparam int ADDR_W = $clog2(DEPTH);

    t_mac_ctrl                w_mac_ctrl;
    t_store_ctrl              w_store_ctrl;
    logic [ADDR_W-1:0]        w_waddr;
    logic [ADDR_W-1:0]        w_raddr;
    logic signed [DATA_W-1:0] w_rdata;
    logic signed [DATA_W-1:0] w_sum;
    logic signed [DATA_W-1:0] w_acc;
    logic                     w_sat;
    logic signed [DATA_W-1:0] w_coef;
    logic signed [DATA_W-1:0] w_x;
    logic                     w_in_ready;
    logic                     w_out_valid;

    // sequencer: holds the word, walks degrees from the top down
    ptae_seq #(
        .MAX_DEGREE (MAX_DEGREE),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_cmd_ch.valid),
        .i_cmd              (i_cmd_ch.cmd),
        .i_term_coefficient (i_cmd_ch.term_coefficient),
        .i_term_degree      (i_cmd_ch.term_degree),
        .i_eval_point       (i_cmd_ch.eval_point),
        .o_in_ready         (w_in_ready),
        .o_out_valid        (w_out_valid),
        .i_out_ready        (o_res_ch.ready),
        .o_mac_ctrl         (w_mac_ctrl),
        .o_store_ctrl       (w_store_ctrl),
        .o_waddr            (w_waddr),
        .o_raddr            (w_raddr),
        .o_coef             (w_coef),
        .o_x                (w_x)
    );

    // coefficient memory, one entry per degree, registered read
    ptae_coef_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_store_ctrl),
        .i_waddr (w_waddr),
        .i_wdata (w_sum),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // shared multiply / round / add / clamp unit, also the result register
    ptae_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_ctrl  (w_mac_ctrl),
        .i_x     (w_x),
        .i_coef  (w_coef),
        .i_rdata (w_rdata),
        .o_sum   (w_sum),
        .o_acc   (w_acc),
        .o_sat   (w_sat)
    );

    assign i_cmd_ch.ready     = w_in_ready;
    assign o_res_ch.valid     = w_out_valid;
    assign o_res_ch.value     = w_acc;
    assign o_res_ch.saturated = w_sat;
endmodule

/* rtl/ptae_checker.sv */
`include "polynomial_term_accumulate_evaluate_core_assert.svh"

module ptae_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic [ptae_pkg::CMD_W-1:0]         i_cmd,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [ptae_pkg::DATA_W-1:0] i_value,
    input logic                               i_saturated
);
    import ptae_pkg::*;

    logic w_in_acc;
    logic w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // never takes a word while a result is pending
    `PTAE_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, i_out_valid, !i_in_ready)

    // busy right after taking a word
    `PTAE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !i_in_ready)

    // one result per word
    `PTAE_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, w_out_acc, !i_out_valid)

    // clear answers zero, unflagged, once it has passed the clear state into done
    `PTAE_ASSERT_NEXT(a_clear_zero, i_clk, i_rst_n, w_in_acc && (i_cmd == CMD_CLEAR),
        ##1 (i_out_valid && (i_value == '0) && !i_saturated))

    // stalled result holds
    `PTAE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_value) && $stable(i_saturated))
endmodule

bind polynomial_term_accumulate_evaluate_core ptae_checker u_ptae_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd_ch.valid),
    .i_in_ready  (i_cmd_ch.ready),
    .i_cmd       (i_cmd_ch.cmd),
    .i_out_valid (o_res_ch.valid),
    .i_out_ready (o_res_ch.ready),
    .i_value     (o_res_ch.value),
    .i_saturated (o_res_ch.saturated)
);
